FILE: hdl/kpg_pkg.sv
// kpg_pkg: shared types, codes and constants of the key-press glow store
// no dependencies; imported by every module under hdl

package kpg_pkg;

   // default geometry, handed down as module parameters
   localparam int MAX_ROWS_DEF  = 16;
   localparam int MAX_COLS_DEF  = 8;
   localparam int LED_COUNT_DEF = 64;

   // position map keeps eight column slots per row
   localparam int MAP_COLS   = 8;
   localparam int MAP_COL_W  = 3;
   localparam int COL_W      = 4;
   localparam int CSR_DATA_W = 7;

   localparam logic [7:0] BOOST_ADD = 8'd16;
   localparam logic [7:0] LEVEL_MAX = 8'd255;
   localparam logic [7:0] NO_LED    = 8'd255;
   localparam logic [7:0] LEVEL_RST = 8'd0;

   localparam logic [3:0] ROW_FIRST_RST  = 4'd0;
   localparam logic [4:0] ROWS_LOCAL_RST = 5'd5;
   localparam logic [6:0] LED_FIRST_RST  = 7'd0;
   localparam logic [6:0] LED_LAST_RST   = 7'd64;

   typedef enum logic [1:0] {
      KIND_SCAN,
      KIND_TICK,
      KIND_MAP,
      KIND_READ
   } kind_type;

   typedef enum logic [1:0] {
      CSR_ROW_FIRST,
      CSR_ROWS_LOCAL,
      CSR_LED_FIRST,
      CSR_LED_LAST
   } csr_index_type;

   typedef enum logic {
      ALU_BOOST,
      ALU_DECAY
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_MAP,
      ST_SCAN_LED,
      ST_SCAN_UPD,
      ST_TICK_MARK,
      ST_DECAY,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  row;
      logic [7:0]  row_bits;
      logic [2:0]  map_col;
      logic [7:0]  map_led;
      logic [5:0]  read_led;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] level;
      logic       glowing;
   } rsp_type;

endpackage

FILE: hdl/kpg_vmem.sv
// kpg_vmem: byte-wide memory, one write and one registered read port a cycle
// per-entry valid bits cleared by reset; an unwritten entry reads as FILL
// depends on kpg_pkg

module kpg_vmem #(
   parameter int         DEPTH  = kpg_pkg::LED_COUNT_DEF,
   parameter int         ADDR_W = 6,
   parameter logic [7:0] FILL   = kpg_pkg::LEVEL_RST
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   import kpg_pkg::*;

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [7:0]       rd_q_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : FILL;

endmodule

FILE: hdl/kpg_level_alu.sv
// kpg_level_alu: shared level update unit, saturating boost or clamped decay
// depends on kpg_pkg

module kpg_level_alu (
   input  kpg_pkg::alu_op_type op,
   input  logic [7:0]          level_cur,
   input  logic [8:0]          dec_amount,
   output logic [7:0]          level_nxt,
   output logic                level_kept
);
   import kpg_pkg::*;

   logic [7:0] add_amt;
   logic [8:0] sum;
   logic [8:0] diff;

   always_comb begin
      // boost shrinks as the level climbs
      add_amt = BOOST_ADD;
      if (level_cur[7]) begin
         add_amt = add_amt >> 2;
      end
      if (level_cur[6]) begin
         add_amt = add_amt >> 1;
      end
      sum        = {1'b0, level_cur} + {1'b0, add_amt};
      diff       = {1'b0, level_cur} - dec_amount;
      level_kept = 1'b0;
      case (op)
         ALU_BOOST: begin
            level_nxt = sum[8] ? LEVEL_MAX : sum[7:0];
         end
         ALU_DECAY: begin
            level_kept = ({1'b0, level_cur} > dec_amount);
            level_nxt  = level_kept ? diff[7:0] : '0;
         end
         default: begin
            level_nxt = level_cur;
         end
      endcase
   end

endmodule

FILE: hdl/keypress_led_glow_decay.sv
// keypress_led_glow_decay: key-press glow store, top level with sequencer
// depends on kpg_pkg, kpg_vmem, kpg_level_alu
//
//   channel  | ports                              | moves
//   ---------+------------------------------------+------------------------------
//   request  | req_valid req_ready req_data       | scan, tick, map write, read
//   response | rsp_valid rsp_ready rsp_data       | level and glowing flag
//   csr      | csr_wr_en csr_index csr_wdata      | row_first rows_local led_*
//
// one request at a time; req_ready is high only while the sequencer is idle.
// scan: walks the columns; each new press reads the map memory, and each press
// mapped to an LED has its level read, boosted and written back. tick: walks
// the local LED range through the single level memory port, reading one LED
// ahead while writing back the one before. a response waiting on rsp_ready
// holds the sequencer in its last step. synchronous reset clears state.

module keypress_led_glow_decay #(
   parameter int MAX_ROWS  = kpg_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = kpg_pkg::MAX_COLS_DEF,
   parameter int LED_COUNT = kpg_pkg::LED_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  kpg_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output kpg_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  kpg_pkg::csr_index_type          csr_index,
   input  logic [kpg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import kpg_pkg::*;

   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int MAP_DEPTH = MAX_ROWS * MAP_COLS;
   localparam int MAP_AW    = ROW_W + MAP_COL_W;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [3:0]  row_first_ff, row_first_in;
   logic [4:0]  rows_local_ff, rows_local_in;
   logic [6:0]  led_first_ff, led_first_in;
   logic [6:0]  led_last_ff, led_last_in;

   logic [7:0]  prev_rows_ff [MAX_ROWS];
   logic [7:0]  prev_rows_in [MAX_ROWS];
   logic [31:0] mark_ff, mark_in;
   logic        active_ff, active_in;
   logic [23:0] elapsed_ff, elapsed_in;
   logic [7:0]  fresh_ff, fresh_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [LED_W-1:0] led_ff, led_in;
   logic [8:0]  dec_ff, dec_in;
   logic [6:0]  rd_ptr_ff, rd_ptr_in;
   logic [6:0]  end_ff, end_in;
   logic        pend_ff, pend_in;
   logic [LED_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [7:0]  level_ff, level_in;

   logic              map_wr_en, map_rd_en;
   logic [MAP_AW-1:0] map_wr_addr, map_rd_addr;
   logic [7:0]        map_rd_data;
   logic              bst_wr_en, bst_rd_en;
   logic [LED_W-1:0]  bst_wr_addr, bst_rd_addr;
   logic [7:0]        bst_wr_data, bst_rd_data;

   alu_op_type  alu_op;
   logic [7:0]  alu_nxt;
   logic        alu_kept;

   logic [ROW_W-1:0] row_idx;
   logic        scan_ok, map_ok, read_ok, col_more, led_ok, issue, rsp_free;
   logic [5:0]  row_stop;
   logic [7:0]  fresh_now;
   logic [31:0] elapsed_now;
   logic [6:0]  led_end;

   kpg_vmem #(
      .DEPTH  (MAP_DEPTH),
      .ADDR_W (MAP_AW),
      .FILL   (NO_LED)
   ) u_map_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (req_ff.map_led),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   kpg_vmem #(
      .DEPTH  (LED_COUNT),
      .ADDR_W (LED_W),
      .FILL   (LEVEL_RST)
   ) u_level_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bst_wr_en),
      .wr_addr (bst_wr_addr),
      .wr_data (bst_wr_data),
      .rd_en   (bst_rd_en),
      .rd_addr (bst_rd_addr),
      .rd_data (bst_rd_data)
   );

   kpg_level_alu u_alu (
      .op         (alu_op),
      .level_cur  (bst_rd_data),
      .dec_amount (dec_ff),
      .level_nxt  (alu_nxt),
      .level_kept (alu_kept)
   );

   // decode of the held request
   always_comb begin
      row_idx     = req_ff.row[ROW_W-1:0];
      row_stop    = {2'b00, row_first_ff} + {1'b0, rows_local_ff};
      scan_ok     = ({1'b0, req_ff.row} < 5'(MAX_ROWS)) &&
                    (req_ff.row >= row_first_ff) &&
                    ({2'b00, req_ff.row} < row_stop);
      map_ok      = ({1'b0, req_ff.row} < 5'(MAX_ROWS)) &&
                    ({1'b0, req_ff.map_col} < COL_W'(MAX_COLS));
      read_ok     = ({1'b0, req_ff.read_led} < 7'(LED_COUNT));
      fresh_now   = req_ff.row_bits & ~prev_rows_ff[row_idx];
      elapsed_now = req_ff.now_ms - mark_ff;
      led_end     = (led_last_ff < 7'(LED_COUNT)) ? led_last_ff : 7'(LED_COUNT);
      col_more    = (col_ff < COL_W'(MAX_COLS));
      led_ok      = (map_rd_data < 8'(LED_COUNT));
      issue       = (rd_ptr_ff < end_ff);
      rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (req_ff.kind)
               KIND_SCAN: state_in = scan_ok ? ST_SCAN_MAP : ST_FINISH;
               KIND_TICK: state_in = active_ff ? ST_TICK_MARK : ST_FINISH;
               KIND_READ: state_in = read_ok ? ST_READ_WAIT : ST_FINISH;
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_SCAN_MAP: begin
            if (!col_more) begin
               state_in = ST_FINISH;
            end else if (fresh_ff[col_ff[MAP_COL_W-1:0]]) begin
               state_in = ST_SCAN_LED;
            end
         end
         ST_SCAN_LED: begin
            state_in = led_ok ? ST_SCAN_UPD : ST_SCAN_MAP;
         end
         ST_SCAN_UPD: begin
            state_in = ST_SCAN_MAP;
         end
         ST_TICK_MARK: begin
            state_in = (elapsed_ff != '0) ? ST_DECAY : ST_FINISH;
         end
         ST_DECAY: begin
            if (!issue && !pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory strobes
   always_comb begin
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      row_first_in  = row_first_ff;
      rows_local_in = rows_local_ff;
      led_first_in  = led_first_ff;
      led_last_in   = led_last_ff;
      prev_rows_in  = prev_rows_ff;
      mark_in       = mark_ff;
      active_in     = active_ff;
      elapsed_in    = elapsed_ff;
      fresh_in      = fresh_ff;
      col_in        = col_ff;
      led_in        = led_ff;
      dec_in        = dec_ff;
      rd_ptr_in     = rd_ptr_ff;
      end_in        = end_ff;
      pend_in       = pend_ff;
      wr_ptr_in     = wr_ptr_ff;
      level_in      = level_ff;
      map_wr_en     = 1'b0;
      map_wr_addr   = {row_idx, req_ff.map_col};
      map_rd_en     = 1'b0;
      map_rd_addr   = {row_idx, col_ff[MAP_COL_W-1:0]};
      bst_wr_en     = 1'b0;
      bst_wr_addr   = led_ff;
      bst_wr_data   = alu_nxt;
      bst_rd_en     = 1'b0;
      bst_rd_addr   = req_ff.read_led[LED_W-1:0];
      alu_op        = ALU_BOOST;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_FIRST:  row_first_in  = csr_wdata[3:0];
            CSR_ROWS_LOCAL: rows_local_in = csr_wdata[4:0];
            CSR_LED_FIRST:  led_first_in  = csr_wdata;
            CSR_LED_LAST:   led_last_in   = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         ST_DISPATCH: begin
            level_in = '0;
            case (req_ff.kind)
               KIND_SCAN: begin
                  if (scan_ok) begin
                     prev_rows_in[row_idx] = req_ff.row_bits;
                     fresh_in              = fresh_now;
                     col_in                = '0;
                  end
               end
               KIND_TICK: begin
                  if (!active_ff) begin
                     mark_in = req_ff.now_ms;
                  end else begin
                     elapsed_in = elapsed_now[31:8];
                  end
               end
               KIND_MAP: begin
                  map_wr_en = map_ok;
               end
               KIND_READ: begin
                  bst_rd_en = read_ok;
               end
               default: ;
            endcase
         end
         ST_SCAN_MAP: begin
            if (col_more) begin
               if (fresh_ff[col_ff[MAP_COL_W-1:0]]) begin
                  map_rd_en = 1'b1;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
         end
         ST_SCAN_LED: begin
            if (led_ok) begin
               bst_rd_en   = 1'b1;
               bst_rd_addr = map_rd_data[LED_W-1:0];
               led_in      = map_rd_data[LED_W-1:0];
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_SCAN_UPD: begin
            bst_wr_en = 1'b1;
            active_in = 1'b1;
            col_in    = col_ff + COL_W'(1);
         end
         ST_TICK_MARK: begin
            if (elapsed_ff != '0) begin
               // the mark moves by whole 256 ms steps only
               mark_in[31:8] = mark_ff[31:8] + elapsed_ff;
               active_in     = 1'b0;
               dec_in        = (elapsed_ff[23:8] != '0) ? 9'd256 : {1'b0, elapsed_ff[7:0]};
               rd_ptr_in     = led_first_ff;
               end_in        = led_end;
               pend_in       = 1'b0;
            end
         end
         ST_DECAY: begin
            // read one LED ahead while writing back the one before
            alu_op      = ALU_DECAY;
            bst_rd_addr = rd_ptr_ff[LED_W-1:0];
            bst_wr_addr = wr_ptr_ff;
            pend_in     = issue;
            if (issue) begin
               bst_rd_en = 1'b1;
               rd_ptr_in = rd_ptr_ff + 7'd1;
               wr_ptr_in = rd_ptr_ff[LED_W-1:0];
            end
            if (pend_ff) begin
               bst_wr_en = 1'b1;
               if (alu_kept) begin
                  active_in = 1'b1;
               end
            end
         end
         ST_READ_WAIT: begin
            level_in = bst_rd_data;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.level   = level_ff;
               rsp_in.glowing = active_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         row_first_ff  <= ROW_FIRST_RST;
         rows_local_ff <= ROWS_LOCAL_RST;
         led_first_ff  <= LED_FIRST_RST;
         led_last_ff   <= LED_LAST_RST;
         mark_ff       <= '0;
         active_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         for (int i = 0; i < MAX_ROWS; i++) begin
            prev_rows_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         row_first_ff  <= row_first_in;
         rows_local_ff <= rows_local_in;
         led_first_ff  <= led_first_in;
         led_last_ff   <= led_last_in;
         mark_ff       <= mark_in;
         active_ff     <= active_in;
         pend_ff       <= pend_in;
         prev_rows_ff  <= prev_rows_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      elapsed_ff <= elapsed_in;
      fresh_ff   <= fresh_in;
      col_ff     <= col_in;
      led_ff     <= led_in;
      dec_ff     <= dec_in;
      rd_ptr_ff  <= rd_ptr_in;
      end_ff     <= end_in;
      wr_ptr_ff  <= wr_ptr_in;
      level_ff   <= level_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted request did not start the sequencer");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FINISH))
      else $error("result dropped while the response slot was busy");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (bst_wr_en && bst_rd_en) |-> (bst_wr_addr != bst_rd_addr))
      else $error("level memory read and write hit the same LED");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_LED || state_ff == ST_SCAN_UPD) |-> col_more)
      else $error("column walk ran past the last column");

endmodule

FILE: dv/glow_checker.sv
// glow_checker: watches the request, response and csr ports of the glow store,
// predicts each response from its own copy of the state and compares in order
// depends on kpg_pkg

module glow_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  kpg_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  kpg_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  kpg_pkg::csr_index_type         csr_index,
   input  logic [kpg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             waiting
);
   import kpg_pkg::*;

   logic [7:0]  glow_level [64];
   logic [7:0]  last_row_bits [16];
   logic [7:0]  led_of_position [128];
   logic [31:0] glow_mark;
   logic        glow_active;

   int cfg_row_first;
   int cfg_rows_local;
   int cfg_led_first;
   int cfg_led_last;

   rsp_type expected_glow [$];
   int n;

   function automatic rsp_type glow_predict(req_type r);
      rsp_type     res;
      int          led;
      int          add;
      int          sum;
      int          led_stop;
      int          i;
      int          c;
      logic [7:0]  fresh;
      logic [7:0]  cur;
      logic [31:0] span;
      logic [31:0] steps;
      res.level = 8'd0;
      case (r.kind)
         KIND_SCAN: begin
            if (int'(r.row) >= cfg_row_first &&
                int'(r.row) < cfg_row_first + cfg_rows_local) begin
               fresh = r.row_bits & ~last_row_bits[r.row];
               for (c = 0; c < 8; c++) begin
                  if (fresh[c]) begin
                     led = led_of_position[r.row * 8 + c];
                     if (led < 64) begin
                        cur = glow_level[led];
                        add = 16;
                        if (cur[7]) add = add >> 2;
                        if (cur[6]) add = add >> 1;
                        sum = cur + add;
                        glow_level[led] = (sum > 255) ? 8'd255 : 8'(sum);
                        glow_active = 1'b1;
                     end
                  end
               end
               last_row_bits[r.row] = r.row_bits;
            end
         end
         KIND_TICK: begin
            if (!glow_active) begin
               glow_mark = r.now_ms;
            end else begin
               span = r.now_ms - glow_mark;
               if (span >= 32'd256) begin
                  steps = span >> 8;
                  glow_mark = glow_mark + (steps << 8);
                  glow_active = 1'b0;
                  led_stop = (cfg_led_last < 64) ? cfg_led_last : 64;
                  for (i = cfg_led_first; i < led_stop; i++) begin
                     if (glow_level[i] > steps) begin
                        glow_level[i] = glow_level[i] - steps[7:0];
                        glow_active = 1'b1;
                     end else begin
                        glow_level[i] = 8'd0;
                     end
                  end
               end
            end
         end
         KIND_MAP: begin
            led_of_position[r.row * 8 + r.map_col] = r.map_led;
         end
         default: begin
            res.level = glow_level[r.read_led];
         end
      endcase
      res.glowing = glow_active;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (n = 0; n < 64; n++) glow_level[n] = 8'd0;
         for (n = 0; n < 16; n++) last_row_bits[n] = 8'd0;
         for (n = 0; n < 128; n++) led_of_position[n] = 8'd255;
         glow_mark = 32'd0;
         glow_active = 1'b0;
         cfg_row_first = 0;
         cfg_rows_local = 5;
         cfg_led_first = 0;
         cfg_led_last = 64;
         expected_glow.delete();
         mismatches = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ROW_FIRST:  cfg_row_first = csr_wdata[3:0];
               CSR_ROWS_LOCAL: cfg_rows_local = csr_wdata[4:0];
               CSR_LED_FIRST:  cfg_led_first = csr_wdata[6:0];
               CSR_LED_LAST:   cfg_led_last = csr_wdata[6:0];
               default: ;
            endcase
         end
         // responses first: a response never belongs to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_glow.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected response: level %0d glowing %0d",
                           rsp_data.level, rsp_data.glowing);
               mismatches++;
            end else begin
               want = expected_glow.pop_front();
               if (rsp_data.level !== want.level || rsp_data.glowing !== want.glowing) begin
                  if (mismatches < 10)
                     $display({"mismatch: expected level %0d glowing %0d, ",
                               "got level %0d glowing %0d"},
                              want.level, want.glowing, rsp_data.level, rsp_data.glowing);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) expected_glow.push_back(glow_predict(req_data));
      end
      waiting = expected_glow.size();
   end

endmodule

FILE: dv/testbench.sv
// testbench: drives directed and random requests and csr settings into
// keypress_led_glow_decay, with glow_checker beside it; depends on kpg_pkg

module testbench;
   import kpg_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 120;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int          mismatches;
   int          waiting;
   int          cycle_count;
   int          hold_arm;
   bit          calm;
   int          cur_row_first;
   int          cur_rows_local;
   logic [31:0] clock_ms;

   keypress_led_glow_decay dut (.*);

   glow_checker check (.*, .mismatches(mismatches), .waiting(waiting));

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** keypress_led_glow_decay: FAILED **");
      $finish;
   end

   // response side: random stalls, plus one long hold-off when asked
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_seen != hold_arm) begin
            hold_seen = hold_arm;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(99) >= 7;
         end
      end
   end

   function automatic req_type pack_request(kind_type k, int row, int bits, int col,
                                            int led, int idx, logic [31:0] now);
      req_type r;
      r.kind = k;
      r.row = 4'(row);
      r.row_bits = 8'(bits);
      r.map_col = 3'(col);
      r.map_led = 8'(led);
      r.read_led = 6'(idx);
      r.now_ms = now;
      return r;
   endfunction

   function automatic req_type make_request();
      req_type r;
      int pick;
      int near_row;
      r.row = 4'($urandom);
      r.row_bits = 8'($urandom);
      r.map_col = 3'($urandom);
      r.map_led = 8'($urandom);
      r.read_led = 6'($urandom);
      r.now_ms = $urandom;
      near_row = cur_row_first + $urandom_range(cur_rows_local - 1);
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.kind = KIND_SCAN;
         if ($urandom_range(9) < 8) r.row = 4'(near_row);
      end else if (pick < 65) begin
         r.kind = KIND_TICK;
         // time mostly creeps forward; now and then it jumps anywhere
         if ($urandom_range(19) == 0) clock_ms = $urandom;
         else clock_ms = clock_ms + $urandom_range(700);
         r.now_ms = clock_ms;
      end else if (pick < 80) begin
         r.kind = KIND_MAP;
         if ($urandom_range(9) < 7) r.row = 4'(near_row);
         pick = $urandom_range(99);
         // a small LED set so levels build up toward saturation
         if (pick < 70) r.map_led = 8'($urandom_range(15));
         else if (pick < 85) r.map_led = 8'($urandom_range(63));
      end else begin
         r.kind = KIND_READ;
         if ($urandom_range(9) < 6) r.read_led = 6'($urandom_range(15));
      end
      return r;
   endfunction

   // call at a falling edge; returns at the falling edge after the request is taken
   task automatic offer(input req_type r);
      if (!calm && $urandom_range(99) < 7) begin
         repeat ($urandom_range(1, 6)) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (waiting != 0) @(negedge clock);
   endtask

   task automatic load_config(input int rf, input int rl, input int lf, input int ll);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ROW_FIRST;
      csr_wdata <= CSR_DATA_W'(rf);
      @(negedge clock);
      csr_index <= CSR_ROWS_LOCAL;
      csr_wdata <= CSR_DATA_W'(rl);
      @(negedge clock);
      csr_index <= CSR_LED_FIRST;
      csr_wdata <= CSR_DATA_W'(lf);
      @(negedge clock);
      csr_index <= CSR_LED_LAST;
      csr_wdata <= CSR_DATA_W'(ll);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_row_first = rf;
      cur_rows_local = rl;
   endtask

   initial begin
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_ROW_FIRST;
      csr_wdata = '0;
      hold_arm = 0;
      calm = 1'b0;
      cur_row_first = 0;
      cur_rows_local = 5;
      clock_ms = 32'd0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed part, reset settings: rows 0..4, all 64 LEDs decay
      offer(pack_request(KIND_READ, 0, 0, 0, 0, 0, 0));
      offer(pack_request(KIND_TICK, 0, 0, 0, 0, 0, 1000));      // idle: mark parks
      offer(pack_request(KIND_MAP, 0, 0, 0, 0, 0, 0));
      offer(pack_request(KIND_MAP, 0, 0, 1, 0, 0, 0));          // two keys, one LED
      offer(pack_request(KIND_MAP, 0, 0, 7, 63, 0, 0));
      offer(pack_request(KIND_MAP, 1, 0, 3, 64, 0, 0));         // first no-LED code
      offer(pack_request(KIND_SCAN, 0, 8'hff, 0, 0, 0, 0));
      offer(pack_request(KIND_SCAN, 0, 8'hff, 0, 0, 0, 0));     // held keys, nothing new
      offer(pack_request(KIND_SCAN, 1, 8'h08, 0, 0, 0, 0));
      offer(pack_request(KIND_SCAN, 7, 8'hff, 0, 0, 0, 0));     // row not local
      offer(pack_request(KIND_READ, 0, 0, 0, 0, 0, 0));
      offer(pack_request(KIND_READ, 0, 0, 0, 0, 63, 0));
      offer(pack_request(KIND_TICK, 0, 0, 0, 0, 0, 1255));      // just short of 256 ms
      offer(pack_request(KIND_TICK, 0, 0, 0, 0, 0, 1768));
      offer(pack_request(KIND_MAP, 4, 0, 7, 200, 0, 0));
      offer(pack_request(KIND_SCAN, 4, 8'h80, 0, 0, 0, 0));
      offer(pack_request(KIND_SCAN, 0, 8'h00, 0, 0, 0, 0));
      offer(pack_request(KIND_SCAN, 0, 8'h01, 0, 0, 0, 0));
      offer(pack_request(KIND_TICK, 0, 0, 0, 0, 0, 32'hffff_ffff)); // huge elapsed time
      offer(pack_request(KIND_READ, 0, 0, 0, 0, 0, 0));
      offer(pack_request(KIND_TICK, 0, 0, 0, 0, 0, 0));
      offer(pack_request(KIND_MAP, 15, 0, 0, 255, 0, 0));
      offer(pack_request(KIND_READ, 0, 0, 0, 0, 63, 0));
      settle();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_config(0, 16, 0, 64);
            1: load_config(15, 1, 63, 64);
            2: load_config(3, 4, 40, 10);        // reversed LED range
            3: load_config(8, 16, 64, 64);       // empty LED range
            default: load_config($urandom_range(15), $urandom_range(1, 16),
                                 $urandom_range(64), $urandom_range(64));
         endcase
         calm = (phase == 1);
         if (phase == 2) hold_arm++;
         repeat (PHASE_ITEMS) offer(make_request());
         settle();
      end

      repeat (80) @(negedge clock);
      if (mismatches == 0 && waiting == 0)
         $display("** keypress_led_glow_decay: PASSED **");
      else
         $display("** keypress_led_glow_decay: FAILED **");
      $finish;
   end

endmodule
